### design/bcw_pkg.sv
// Shared widths and types for the barycentric weights unit.
// No dependencies; every other design file refers to this package by scoped names.
package bcw_pkg;

    localparam int COORD_W  = 24;
    localparam int EDGE_W   = 25;
    localparam int PROD_W   = 50;
    localparam int CROSS_W  = 50;
    localparam int HALF_W   = 25;
    localparam int SQ_W     = 100;
    localparam int SUM_W    = 102;
    localparam int ROOT_W   = 51;
    localparam int THR_W    = 52;
    localparam int WEIGHT_W = 20;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vec_t;

endpackage

### design/bcw_area.sv
// Squared length of the cross product of two triangle edges, six register stages.
// Depends on bcw_pkg.
module bcw_area (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  bcw_pkg::vec_t                p,
    input  bcw_pkg::vec_t                q,
    input  bcw_pkg::vec_t                r,
    output logic                         out_valid,
    output logic [bcw_pkg::SUM_W-1:0]    sum_sq
);

    logic [5:0] valid_reg;

    logic signed [bcw_pkg::EDGE_W-1:0]  e0x_reg, e0y_reg, e0z_reg, e1x_reg, e1y_reg, e1z_reg;
    logic signed [bcw_pkg::PROD_W-1:0]  m_reg [6];
    logic [bcw_pkg::CROSS_W-1:0]        c_reg [3];
    logic [bcw_pkg::PROD_W-1:0]         hh_reg [3];
    logic [bcw_pkg::PROD_W-1:0]         hl_reg [3];
    logic [bcw_pkg::PROD_W-1:0]         ll_reg [3];
    logic [bcw_pkg::SQ_W-1:0]           sq_reg [3];
    logic [bcw_pkg::SUM_W-1:0]          sum_reg;

    logic signed [bcw_pkg::CROSS_W:0]   d_next [3];

    always_comb
    begin
        d_next[0] = $signed({m_reg[0][bcw_pkg::PROD_W-1], m_reg[0]})
                  - $signed({m_reg[1][bcw_pkg::PROD_W-1], m_reg[1]});
        d_next[1] = $signed({m_reg[2][bcw_pkg::PROD_W-1], m_reg[2]})
                  - $signed({m_reg[3][bcw_pkg::PROD_W-1], m_reg[3]});
        d_next[2] = $signed({m_reg[4][bcw_pkg::PROD_W-1], m_reg[4]})
                  - $signed({m_reg[5][bcw_pkg::PROD_W-1], m_reg[5]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Edges from the first corner.
            e0x_reg <= $signed({q.x[bcw_pkg::COORD_W-1], q.x}) - $signed({p.x[bcw_pkg::COORD_W-1], p.x});
            e0y_reg <= $signed({q.y[bcw_pkg::COORD_W-1], q.y}) - $signed({p.y[bcw_pkg::COORD_W-1], p.y});
            e0z_reg <= $signed({q.z[bcw_pkg::COORD_W-1], q.z}) - $signed({p.z[bcw_pkg::COORD_W-1], p.z});
            e1x_reg <= $signed({r.x[bcw_pkg::COORD_W-1], r.x}) - $signed({p.x[bcw_pkg::COORD_W-1], p.x});
            e1y_reg <= $signed({r.y[bcw_pkg::COORD_W-1], r.y}) - $signed({p.y[bcw_pkg::COORD_W-1], p.y});
            e1z_reg <= $signed({r.z[bcw_pkg::COORD_W-1], r.z}) - $signed({p.z[bcw_pkg::COORD_W-1], p.z});
            // Cross product terms.
            m_reg[0] <= e0y_reg * e1z_reg;
            m_reg[1] <= e0z_reg * e1y_reg;
            m_reg[2] <= e0z_reg * e1x_reg;
            m_reg[3] <= e0x_reg * e1z_reg;
            m_reg[4] <= e0x_reg * e1y_reg;
            m_reg[5] <= e0y_reg * e1x_reg;
            for (int k = 0; k < 3; k++)
            begin
                // The magnitude stays below 2^50, so the low bits hold it.
                c_reg[k] <= d_next[k][bcw_pkg::CROSS_W] ? bcw_pkg::CROSS_W'(-d_next[k])
                                                        : bcw_pkg::CROSS_W'(d_next[k]);
                // Each square is split into halves to keep the multipliers narrow.
                hh_reg[k] <= c_reg[k][bcw_pkg::CROSS_W-1:bcw_pkg::HALF_W]
                           * c_reg[k][bcw_pkg::CROSS_W-1:bcw_pkg::HALF_W];
                hl_reg[k] <= c_reg[k][bcw_pkg::CROSS_W-1:bcw_pkg::HALF_W]
                           * c_reg[k][bcw_pkg::HALF_W-1:0];
                ll_reg[k] <= c_reg[k][bcw_pkg::HALF_W-1:0] * c_reg[k][bcw_pkg::HALF_W-1:0];
                sq_reg[k] <= (bcw_pkg::SQ_W'(hh_reg[k]) << (2 * bcw_pkg::HALF_W))
                           + (bcw_pkg::SQ_W'(hl_reg[k]) << (bcw_pkg::HALF_W + 1))
                           + bcw_pkg::SQ_W'(ll_reg[k]);
            end
            sum_reg <= bcw_pkg::SUM_W'(sq_reg[0]) + bcw_pkg::SUM_W'(sq_reg[1])
                     + bcw_pkg::SUM_W'(sq_reg[2]);
        end
    end

    assign out_valid = valid_reg[5];
    assign sum_sq    = sum_reg;

endmodule

### design/bcw_isqrt.sv
// Pipelined floor square root, one result bit per register stage.
// Depends on bcw_pkg.
module bcw_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [bcw_pkg::SUM_W-1:0]     radicand,
    output logic                          out_valid,
    output logic [bcw_pkg::ROOT_W-1:0]    root
);

    localparam int N  = bcw_pkg::ROOT_W;
    localparam int RW = bcw_pkg::ROOT_W + 3;

    logic [N-1:0]                 valid_reg;
    logic [bcw_pkg::SUM_W-1:0]    s_reg    [N];
    logic [RW-1:0]                rem_reg  [N];
    logic [N-1:0]                 root_reg [N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[N-2:0], in_valid};
        end
    end

    for (genvar g = 0; g < N; g++)
    begin : g_step
        logic [bcw_pkg::SUM_W-1:0] s_in;
        logic [RW-1:0]             rem_in;
        logic [N-1:0]              root_in;
        logic [RW-1:0]             rem_sh;
        logic [RW-1:0]             trial;

        if (g == 0)
        begin : g_first
            assign s_in    = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign s_in    = s_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
        end

        // Bring down the next two radicand bits and try appending a one.
        assign rem_sh = {rem_in[RW-3:0], s_in[bcw_pkg::SUM_W-1 -: 2]};
        assign trial  = RW'({root_in, 2'b01});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[g] <= {s_in[bcw_pkg::SUM_W-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg[g]  <= rem_sh - trial;
                    root_reg[g] <= {root_in[N-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[g]  <= rem_sh;
                    root_reg[g] <= {root_in[N-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign root      = root_reg[N-1];

endmodule

### design/bcw_div.sv
// Pipelined saturating quotient of a sub-area over the full area, one bit per step.
// Depends on bcw_pkg.
module bcw_div #(
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [bcw_pkg::ROOT_W-1:0]     sub2,
    input  logic [bcw_pkg::ROOT_W-1:0]     full2,
    input  logic [bcw_pkg::THR_W-1:0]      threshold,
    output logic                           out_valid,
    output logic [bcw_pkg::WEIGHT_W-1:0]   weight,
    output logic                           degenerate
);

    localparam int QW = bcw_pkg::WEIGHT_W;
    localparam int CW = bcw_pkg::ROOT_W
                      + ((WEIGHT_FRAC_BITS > QW) ? WEIGHT_FRAC_BITS : QW) + 1;

    logic [QW:0]                  valid_reg;
    logic [CW-1:0]                rem_reg  [QW+1];
    logic [bcw_pkg::ROOT_W-1:0]   den_reg  [QW+1];
    logic [QW-1:0]                quo_reg  [QW+1];
    logic                         degen_reg [QW+1];
    logic                         zero_reg [QW+1];
    logic                         sat_reg  [QW+1];

    logic [CW-1:0] num_next;
    logic [CW-1:0] lim_next;

    assign num_next = CW'(sub2) << WEIGHT_FRAC_BITS;
    assign lim_next = CW'(full2) << QW;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[QW-1:0], in_valid};
        end
    end

    // Entry stage: flags for the special cases, and the scaled numerator.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]   <= num_next;
            den_reg[0]   <= full2;
            quo_reg[0]   <= '0;
            degen_reg[0] <= (full2 == '0);
            zero_reg[0]  <= ({2'b00, sub2} < {threshold, 1'b0});
            sat_reg[0]   <= (num_next >= lim_next);
        end
    end

    for (genvar g = 1; g <= QW; g++)
    begin : g_step
        logic [CW-1:0] shifted_den;

        assign shifted_den = CW'(den_reg[g-1]) << (QW - g);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[g]   <= den_reg[g-1];
                degen_reg[g] <= degen_reg[g-1];
                zero_reg[g]  <= zero_reg[g-1];
                sat_reg[g]   <= sat_reg[g-1];
                if (rem_reg[g-1] >= shifted_den)
                begin
                    rem_reg[g] <= rem_reg[g-1] - shifted_den;
                    quo_reg[g] <= {quo_reg[g-1][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[g] <= rem_reg[g-1];
                    quo_reg[g] <= {quo_reg[g-1][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        if (degen_reg[QW] || zero_reg[QW])
        begin
            weight = '0;
        end
        else if (sat_reg[QW])
        begin
            weight = bcw_pkg::WEIGHT_MAX;
        end
        else
        begin
            weight = quo_reg[QW];
        end
    end

    assign out_valid  = valid_reg[QW];
    assign degenerate = degen_reg[QW];

endmodule

### design/barycentric_weights_3d_unit.sv
// Top level of the barycentric weights unit: four area pipelines, four square roots,
// three dividers. Depends on bcw_pkg, bcw_area, bcw_isqrt and bcw_div.

// This unit accepts one transaction per clock cycle while in_stall is low
// and returns one result transaction for each, in order, after the edge,
// cross product and squaring stages, the square root stages (one root bit
// per stage) and the division stages (one entry stage and one quotient bit per
// stage). The whole pipeline advances as one; it holds when a result is
// waiting and out_stall is high, and in_stall then goes high as well. Empty
// slots in the pipeline move along with the rest, so a waiting result only
// stalls the input side while the output is backed up.
//
// Each weight is the twice-area of the sub-triangle opposite its corner over
// the twice-area of the full triangle, truncated to unsigned Q4.16 and
// saturated at its maximum. A sub-area below area_threshold gives a zero
// weight. A zero full area sets the degenerate flag and zeroes all weights.
// The user must write the threshold register (cfg_write_en, cfg_write_data)
// only while no transaction is in flight; the block does not enforce this.
module barycentric_weights_3d_unit #(
    parameter int COORD_FRAC_BITS  = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [bcw_pkg::THR_W-1:0]            cfg_write_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [bcw_pkg::COORD_W-1:0]   point_x,
    input  logic signed [bcw_pkg::COORD_W-1:0]   point_y,
    input  logic signed [bcw_pkg::COORD_W-1:0]   point_z,
    input  logic signed [bcw_pkg::COORD_W-1:0]   corner_a_x,
    input  logic signed [bcw_pkg::COORD_W-1:0]   corner_a_y,
    input  logic signed [bcw_pkg::COORD_W-1:0]   corner_a_z,
    input  logic signed [bcw_pkg::COORD_W-1:0]   corner_b_x,
    input  logic signed [bcw_pkg::COORD_W-1:0]   corner_b_y,
    input  logic signed [bcw_pkg::COORD_W-1:0]   corner_b_z,
    input  logic signed [bcw_pkg::COORD_W-1:0]   corner_c_x,
    input  logic signed [bcw_pkg::COORD_W-1:0]   corner_c_y,
    input  logic signed [bcw_pkg::COORD_W-1:0]   corner_c_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [bcw_pkg::WEIGHT_W-1:0]         weight_a,
    output logic [bcw_pkg::WEIGHT_W-1:0]         weight_b,
    output logic [bcw_pkg::WEIGHT_W-1:0]         weight_c,
    output logic                                 degenerate
);

    // The reset threshold is about 1e-8 in the squared coordinate scale.
    localparam logic [bcw_pkg::THR_W-1:0] THR_RESET = bcw_pkg::THR_W'(
        ((64'd1 << (2 * COORD_FRAC_BITS)) + 64'd50000000) / 64'd100000000);

    logic [bcw_pkg::THR_W-1:0] threshold_reg;

    logic en;
    bcw_pkg::vec_t pt, ca, cb, cc;

    logic [bcw_pkg::SUM_W-1:0]  sq_full, sq_a, sq_b, sq_c;
    logic [bcw_pkg::ROOT_W-1:0] rt_full, rt_a, rt_b, rt_c;
    logic                       area_valid, root_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THR_RESET;
        end
        else if (cfg_write_en)
        begin
            threshold_reg <= cfg_write_data;
        end
    end

    // The pipeline moves unless a finished result is being held back.
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    assign pt = '{x: point_x,    y: point_y,    z: point_z};
    assign ca = '{x: corner_a_x, y: corner_a_y, z: corner_a_z};
    assign cb = '{x: corner_b_x, y: corner_b_y, z: corner_b_z};
    assign cc = '{x: corner_c_x, y: corner_c_y, z: corner_c_z};

    // All parallel lanes have the same latency, so one lane's valid stands for all.
    bcw_area u_area_full (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
        .p(ca), .q(cb), .r(cc), .out_valid(area_valid), .sum_sq(sq_full)
    );
    bcw_area u_area_a (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
        .p(pt), .q(cb), .r(cc), .out_valid(), .sum_sq(sq_a)
    );
    bcw_area u_area_b (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
        .p(ca), .q(pt), .r(cc), .out_valid(), .sum_sq(sq_b)
    );
    bcw_area u_area_c (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
        .p(ca), .q(cb), .r(pt), .out_valid(), .sum_sq(sq_c)
    );

    bcw_isqrt u_sqrt_full (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(area_valid),
        .radicand(sq_full), .out_valid(root_valid), .root(rt_full)
    );
    bcw_isqrt u_sqrt_a (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(area_valid),
        .radicand(sq_a), .out_valid(), .root(rt_a)
    );
    bcw_isqrt u_sqrt_b (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(area_valid),
        .radicand(sq_b), .out_valid(), .root(rt_b)
    );
    bcw_isqrt u_sqrt_c (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(area_valid),
        .radicand(sq_c), .out_valid(), .root(rt_c)
    );

    bcw_div #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_div_a (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(root_valid),
        .sub2(rt_a), .full2(rt_full), .threshold(threshold_reg),
        .out_valid(out_valid), .weight(weight_a), .degenerate(degenerate)
    );
    bcw_div #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_div_b (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(root_valid),
        .sub2(rt_b), .full2(rt_full), .threshold(threshold_reg),
        .out_valid(), .weight(weight_b), .degenerate()
    );
    bcw_div #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_div_c (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(root_valid),
        .sub2(rt_c), .full2(rt_full), .threshold(threshold_reg),
        .out_valid(), .weight(weight_c), .degenerate()
    );

endmodule

### design/bcw_checker.sv
// Port-level checks for the barycentric weights unit, and the bind that attaches them.
// Depends on bcw_pkg and barycentric_weights_3d_unit.
module bcw_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_stall,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [bcw_pkg::WEIGHT_W-1:0]   weight_a,
    input  logic [bcw_pkg::WEIGHT_W-1:0]   weight_b,
    input  logic [bcw_pkg::WEIGHT_W-1:0]   weight_c,
    input  logic                           degenerate
);

    // The input side holds back only while a result is held back.
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("in_stall does not follow the held-back output");

    // A degenerate triangle carries zero weights.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |-> (weight_a == '0 && weight_b == '0 && weight_c == '0))
        else $error("degenerate result with nonzero weights");

    // A held-back result stays valid.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("output valid dropped while stalled");

    // A held-back result keeps its payload.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(weight_a) && $stable(weight_b)
                                      && $stable(weight_c) && $stable(degenerate)))
        else $error("output payload changed while stalled");

endmodule

bind barycentric_weights_3d_unit bcw_checker u_bcw_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
    .out_stall(out_stall), .weight_a(weight_a), .weight_b(weight_b),
    .weight_c(weight_c), .degenerate(degenerate)
);
